// ----- design/ddrn_pkg.sv -----
`timescale 1ns / 1ps
package ddrn_pkg;

  // magnitude thresholds on the 63 bits below the sign
  localparam logic [62:0] ABS_TWO52 = 63'h4330000000000000;
  localparam logic [62:0] ABS_TWO53 = 63'h4340000000000000;
  localparam logic [62:0] ABS_INF   = 63'h7FF0000000000000;
  localparam logic [63:0] QUIET_BIT = 64'h0008000000000000;

  // fixed-point window: LSB weight 2^-57, bit 0 is a sticky bit for bits below 2^-56
  localparam int unsigned FXW = 111;
  localparam int unsigned FRW = 57;
  localparam int unsigned RW  = 56;  // rounded integer magnitude
  localparam int unsigned GW  = 58;  // large-sum adder window

  // result source selectors
  localparam logic [1:0] SEL_RAW = 2'd0;
  localparam logic [1:0] SEL_FIX = 2'd1;
  localparam logic [1:0] SEL_FAR = 2'd2;

  typedef struct packed {
    logic [1:0] hi;
    logic [1:0] lo;
  } sel_t;

  // magnitude of a finite double (|x| <= 2^53) as fixed point, tail folded into bit 0
  function automatic logic [FXW-1:0] to_fixed(input logic [63:0] x);
    logic [10:0]    ef;
    logic [52:0]    m;
    logic [11:0]    rsh;
    logic [5:0]     rc;
    logic [116:0]   sh;
    logic [FXW-1:0] res;
    ef = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
    m  = {(x[62:52] != 11'd0), x[51:0]};
    if (ef >= 11'd1018) begin
      res = {{(FXW-53){1'b0}}, m} << (ef - 11'd1018);
    end else begin
      rsh = 12'd1018 - {1'b0, ef};
      rc  = (rsh > 12'd63) ? 6'd63 : rsh[5:0];
      sh  = {m, 64'd0} >> rc;
      res = {{(FXW-53){1'b0}}, sh[116:65], sh[64] | (|sh[63:0])};
    end
    return res;
  endfunction

endpackage

// ----- design/double_double_round_nearest_top.sv -----
`timescale 1ns / 1ps
// Channel  Dir  tdata fields (low bit up)        Handshake
// s_axis   in   high_bits[63:0], low_bits[127:64]  tvalid/tready
// m_axis   out  high_result[63:0], low_result[127:64]  tvalid/tready
//
// Five register stages: classify/align, add, round, leading-one search,
// normalize/pack into the output register. One transaction per cycle is
// sustained while the output is not stalled.
// Each stage advances when it is empty or the next one advances, so
// bubbles fill up while the output stalls. Reset clears only the valids.
module double_double_round_nearest_top import ddrn_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // high_bits, low_bits
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // high_result, low_result
);

  // stage control
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = ~v5_q | m_axis_tready;
  assign en4 = ~v4_q | en5;
  assign en3 = ~v3_q | en4;
  assign en2 = ~v2_q | en3;
  assign en1 = ~v1_q | en2;
  assign s_axis_tready = en1;
  assign m_axis_tvalid = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // ---------------- stage 1: classify, convert, align ----------------
  logic [63:0]    hb, lb, opa, opb;
  logic [62:0]    habs, labs;
  logic           small_h, mid_case;
  sel_t           sel1_d;
  logic [63:0]    p0_1_d, p1_1_d;
  logic [10:0]    he;
  logic [52:0]    mh;
  logic [11:0]    fsh;
  logic [5:0]     fshc;
  logic [117:0]   fext;

  assign hb   = s_axis_tdata[63:0];
  assign lb   = s_axis_tdata[127:64];
  assign habs = hb[62:0];
  assign labs = lb[62:0];
  assign small_h  = habs < ABS_TWO52;
  assign mid_case = !small_h && (habs <= ABS_INF) && (labs < ABS_TWO52);

  // fixed path rounds high+low, or low alone when high is already integral
  assign opa = mid_case ? lb : hb;
  assign opb = mid_case ? 64'd0 : lb;

  always_comb begin
    sel1_d = '{hi: SEL_RAW, lo: SEL_RAW};
    p0_1_d = hb;
    p1_1_d = lb;
    if (small_h) begin
      p1_1_d = 64'd0;
      if (labs > ABS_INF) begin
        p0_1_d = lb | QUIET_BIT;
      end else if (labs == ABS_INF) begin
        p0_1_d = lb;
      end else if (labs > ABS_TWO53) begin
        sel1_d.hi = SEL_FAR;
      end else begin
        sel1_d.hi = SEL_FIX;
      end
    end else if (mid_case) begin
      sel1_d.lo = SEL_FIX;
    end
  end

  // large-sum path: high aligned under the low significand, sticky in bit 0
  assign he   = (hb[62:52] == 11'd0) ? 11'd1 : hb[62:52];
  assign mh   = {(hb[62:52] != 11'd0), hb[51:0]};
  assign fsh  = {1'b0, lb[62:52]} - {1'b0, he} - 12'd2;
  assign fshc = (fsh > 12'd63) ? 6'd63 : fsh[5:0];
  assign fext = {mh, 1'b0, 64'd0} >> fshc;

  sel_t           sel1_q;
  logic [63:0]    p0_1_q, p1_1_q;
  logic [FXW-1:0] fa_q, fb_q;
  logic           sa_q, sb_q, dir1_q;
  logic [GW-1:0]  lal_q, hal_q;
  logic           fsub1_q, fsgn1_q;
  logic [10:0]    fe1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      sel1_q  <= sel1_d;
      p0_1_q  <= p0_1_d;
      p1_1_q  <= p1_1_d;
      fa_q    <= to_fixed(opa);
      fb_q    <= to_fixed(opb);
      sa_q    <= opa[63];
      sb_q    <= opb[63];
      dir1_q  <= ~opa[63] & (|opa[62:0]);
      lal_q   <= {2'd0, 1'b1, lb[51:0], 3'd0};
      hal_q   <= {4'd0, fext[117:65], fext[64] | (|fext[63:0])};
      fsub1_q <= hb[63] ^ lb[63];
      fsgn1_q <= lb[63];
      fe1_q   <= lb[62:52];
    end
  end

  // ---------------- stage 2: signed add ----------------
  logic [FXW:0] sum_fx, dab, dba, mag2_d;
  logic         sx2_d;

  assign sum_fx = {1'b0, fa_q} + {1'b0, fb_q};
  assign dab    = {1'b0, fa_q} - {1'b0, fb_q};
  assign dba    = {1'b0, fb_q} - {1'b0, fa_q};

  always_comb begin
    if (sa_q == sb_q) begin
      mag2_d = sum_fx;
      sx2_d  = sa_q;
    end else if (!dab[FXW]) begin
      mag2_d = dab;
      sx2_d  = sa_q;
    end else begin
      mag2_d = dba;
      sx2_d  = sb_q;
    end
  end

  sel_t          sel2_q;
  logic [63:0]   p0_2_q, p1_2_q;
  logic [FXW:0]  mag2_q;
  logic          sx2_q, dir2_q, fsgn2_q;
  logic [GW-1:0] fs2_q;
  logic [10:0]   fe2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      sel2_q  <= sel1_q;
      p0_2_q  <= p0_1_q;
      p1_2_q  <= p1_1_q;
      mag2_q  <= mag2_d;
      sx2_q   <= sx2_d;
      dir2_q  <= dir1_q;
      fs2_q   <= fsub1_q ? (lal_q - hal_q) : (lal_q + hal_q);
      fsgn2_q <= fsgn1_q;
      fe2_q   <= fe1_q;
    end
  end

  // ---------------- stage 3: round ----------------
  logic [54:0]   ip;
  logic          half, rest, big, two, inc1, inc2;
  logic [RW-1:0] rnd3_d;

  assign ip   = mag2_q[FXW:FRW];
  assign half = mag2_q[FRW-1];
  assign rest = |mag2_q[FRW-2:0];
  assign big  = |ip[54:52];
  assign two  = |ip[54:53];
  // below 2^52 ties follow the direction of the leading part, above it ties go even
  assign inc1 = half & (rest | (big ? ip[0] : (dir2_q ^ sx2_q)));
  assign inc2 = ip[0] & (half | rest | ip[1]);
  assign rnd3_d = two ? ({1'b0, ip[54:1], 1'b0} + {54'd0, inc2, 1'b0})
                      : ({1'b0, ip} + {55'd0, inc1});

  // large sum: normalize by at most two places, round to nearest even
  logic [GW-1:0] fn;
  logic [11:0]   fesel, fexp;
  logic [52:0]   fsig;
  logic          finc;
  logic [53:0]   fsum;

  always_comb begin
    if (fs2_q[56]) begin
      fn    = fs2_q;
      fesel = {1'b0, fe2_q} + 12'd1;
    end else if (fs2_q[55]) begin
      fn    = fs2_q << 1;
      fesel = {1'b0, fe2_q};
    end else begin
      fn    = fs2_q << 2;
      fesel = {1'b0, fe2_q} - 12'd1;
    end
  end

  assign fsig = fn[56:4];
  assign finc = fn[3] & ((|fn[2:0]) | fsig[0]);
  assign fsum = {1'b0, fsig} + {53'd0, finc};
  assign fexp = fesel + {11'd0, fsum[53]};

  sel_t          sel3_q;
  logic [63:0]   p0_3_q, p1_3_q, far3_q;
  logic [RW-1:0] rnd3_q;
  logic          sx3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      sel3_q <= sel2_q;
      p0_3_q <= p0_2_q;
      p1_3_q <= p1_2_q;
      rnd3_q <= rnd3_d;
      sx3_q  <= sx2_q;
      far3_q <= {fsgn2_q, fexp[10:0], fsum[51:0]};
    end
  end

  // ---------------- stage 4: leading-one search ----------------
  logic [5:0] pos4_d;

  always_comb begin
    pos4_d = 6'd0;
    for (int i = 0; i < RW; i++) begin
      if (rnd3_q[i]) pos4_d = 6'(i);
    end
  end

  sel_t          sel4_q;
  logic [63:0]   p0_4_q, p1_4_q, far4_q;
  logic [RW-1:0] rnd4_q;
  logic          sx4_q;
  logic [5:0]    pos4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      sel4_q <= sel3_q;
      p0_4_q <= p0_3_q;
      p1_4_q <= p1_3_q;
      far4_q <= far3_q;
      rnd4_q <= rnd3_q;
      sx4_q  <= sx3_q;
      pos4_q <= pos4_d;
    end
  end

  // ---------------- stage 5: pack and select ----------------
  logic [RW-1:0] nrm;
  logic [63:0]   fix5, out0_d, out1_d;

  assign nrm  = rnd4_q << (6'd55 - pos4_q);
  // a zero integer is always +0
  assign fix5 = (|rnd4_q) ? {sx4_q, {5'd0, pos4_q} + 11'd1023, nrm[54:3]} : 64'd0;

  always_comb begin
    case (sel4_q.hi)
      SEL_FIX: out0_d = fix5;
      SEL_FAR: out0_d = far4_q;
      default: out0_d = p0_4_q;
    endcase
    case (sel4_q.lo)
      SEL_FIX: out1_d = fix5;
      default: out1_d = p1_4_q;
    endcase
  end

  logic [63:0] out0_q, out1_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      out0_q <= out0_d;
      out1_q <= out1_d;
    end
  end

  assign m_axis_tdata = {out1_q, out0_q};

endmodule

// ----- design/ddrn_checker.sv -----
`timescale 1ns / 1ps
module ddrn_props (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // an empty or draining output lets the whole pipeline move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled with free output");

  // no result once a reset edge has been seen
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid in reset");

  // the input is refused only while the output holds a stalled result
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input refused without output stall");

endmodule

bind double_double_round_nearest_top ddrn_props u_ddrn_props (.*);
